// ----- sv/srpp_pkg.sv -----
// srpp_pkg: shared constants and types of the stride read prefetch predictor
// holds field widths, stream word layout, action codes and the flag struct
// no dependencies
`default_nettype none

package srpp_pkg;

   // default sizing of the predictor table and its counters
   localparam int ENTRIES_DEF     = 16;
   localparam int OFFSET_BITS_DEF = 48;
   localparam int COUNT_BITS_DEF  = 32;

   // fixed field widths at the ports
   localparam int ACTION_BITS  = 2;
   localparam int HANDLE_BITS  = 4;
   localparam int POS_BITS     = 48;
   localparam int SIZE_BITS    = 32;
   localparam int CNT_OUT_BITS = 32;
   localparam int THR_BITS     = 8;

   localparam logic [THR_BITS-1:0] THR_RESET = 8'd4;

   // stream word widths, padded to whole bytes
   localparam int REQ_FIELD_BITS = ACTION_BITS + HANDLE_BITS + POS_BITS + SIZE_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + POS_BITS + SIZE_BITS + 1 + 1
                                   + 4 * CNT_OUT_BITS + POS_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // access kinds
   localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_OPEN  = 2'd2;

   // per-access status flags
   typedef struct packed {
      logic pf_valid;
      logic hit;
      logic conflict;
   } flag_type;

endpackage

`default_nettype wire

// ----- sv/srpp_update.sv -----
// srpp_update: next-state logic for one predictor table entry
// pure combinational read/write/open update with saturating counters
// depends on srpp_pkg
`default_nettype none

module srpp_update #(
   parameter int OFFSET_BITS = srpp_pkg::OFFSET_BITS_DEF,
   parameter int COUNT_BITS  = srpp_pkg::COUNT_BITS_DEF
) (
   input  logic [srpp_pkg::ACTION_BITS-1:0] action,
   input  logic [OFFSET_BITS-1:0]           position,
   input  logic [srpp_pkg::SIZE_BITS-1:0]   byte_count,
   input  logic [srpp_pkg::THR_BITS-1:0]    threshold,
   input  logic [COUNT_BITS-1:0]            cur_run,
   input  logic [COUNT_BITS-1:0]            cur_hit,
   input  logic [COUNT_BITS-1:0]            cur_miss,
   input  logic [COUNT_BITS-1:0]            cur_pf_count,
   input  logic [OFFSET_BITS-1:0]           cur_pf_sum,
   input  logic [OFFSET_BITS-1:0]           cur_pred_offset,
   input  logic [srpp_pkg::SIZE_BITS-1:0]   cur_pred_size,
   input  logic [OFFSET_BITS-1:0]           cur_prev_offset,
   output logic [COUNT_BITS-1:0]            nxt_run,
   output logic [COUNT_BITS-1:0]            nxt_hit,
   output logic [COUNT_BITS-1:0]            nxt_miss,
   output logic [COUNT_BITS-1:0]            nxt_pf_count,
   output logic [OFFSET_BITS-1:0]           nxt_pf_sum,
   output logic [OFFSET_BITS-1:0]           nxt_pred_offset,
   output logic [srpp_pkg::SIZE_BITS-1:0]   nxt_pred_size,
   output logic [OFFSET_BITS-1:0]           nxt_prev_offset,
   output srpp_pkg::flag_type               flags
);

   // exact sums of an offset and a length never wrap at this width
   localparam int SUM_BITS = ((OFFSET_BITS > srpp_pkg::SIZE_BITS) ?
                              OFFSET_BITS : srpp_pkg::SIZE_BITS) + 1;

   logic [COUNT_BITS-1:0]  run_inc;
   logic [COUNT_BITS-1:0]  hit_inc;
   logic [COUNT_BITS-1:0]  miss_inc;
   logic [COUNT_BITS-1:0]  pf_inc;
   logic [COUNT_BITS-1:0]  run_rd;
   logic                   read_hit;
   logic                   pf_fire;
   logic [OFFSET_BITS-1:0] stride_offset;
   logic [SUM_BITS-1:0]    sum_full;
   logic [OFFSET_BITS-1:0] sum_sat;
   logic [SUM_BITS-1:0]    end_access;
   logic [SUM_BITS-1:0]    end_pred;
   logic                   overlap;

   assign run_inc  = (&cur_run)      ? cur_run      : cur_run + COUNT_BITS'(1);
   assign hit_inc  = (&cur_hit)      ? cur_hit      : cur_hit + COUNT_BITS'(1);
   assign miss_inc = (&cur_miss)     ? cur_miss     : cur_miss + COUNT_BITS'(1);
   assign pf_inc   = (&cur_pf_count) ? cur_pf_count : cur_pf_count + COUNT_BITS'(1);

   assign read_hit = (position == cur_pred_offset) && (byte_count == cur_pred_size);
   assign run_rd   = read_hit ? run_inc : '0;
   assign pf_fire  = run_rd > COUNT_BITS'(threshold);

   // repeat the last stride, wrapping at the offset width
   assign stride_offset = position + (position - cur_prev_offset);

   assign sum_full = SUM_BITS'(cur_pf_sum) + SUM_BITS'(byte_count);
   assign sum_sat  = ((sum_full >> OFFSET_BITS) != '0) ? '1 : sum_full[OFFSET_BITS-1:0];

   assign end_access = SUM_BITS'(position) + SUM_BITS'(byte_count);
   assign end_pred   = SUM_BITS'(cur_pred_offset) + SUM_BITS'(cur_pred_size);
   assign overlap    = (end_access > SUM_BITS'(cur_pred_offset)) &&
                       (end_pred > SUM_BITS'(position));

   always_comb begin
      nxt_run         = cur_run;
      nxt_hit         = cur_hit;
      nxt_miss        = cur_miss;
      nxt_pf_count    = cur_pf_count;
      nxt_pf_sum      = cur_pf_sum;
      nxt_pred_offset = cur_pred_offset;
      nxt_pred_size   = cur_pred_size;
      nxt_prev_offset = cur_prev_offset;
      flags           = '0;
      unique case (action)
         srpp_pkg::ACT_READ: begin
            flags.hit       = read_hit;
            flags.pf_valid  = pf_fire;
            nxt_run         = run_rd;
            nxt_hit         = read_hit ? hit_inc : cur_hit;
            nxt_miss        = read_hit ? cur_miss : miss_inc;
            nxt_pred_size   = byte_count;
            nxt_pred_offset = stride_offset;
            nxt_prev_offset = position;
            if (pf_fire) begin
               nxt_pf_count = pf_inc;
               nxt_pf_sum   = sum_sat;
            end
         end
         srpp_pkg::ACT_WRITE: begin
            flags.conflict = overlap;
            if (overlap) begin
               nxt_run = '0;
            end
         end
         srpp_pkg::ACT_OPEN: begin
            nxt_run         = '0;
            nxt_hit         = '0;
            nxt_miss        = '0;
            nxt_pf_count    = '0;
            nxt_pf_sum      = '0;
            nxt_pred_offset = '0;
            nxt_pred_size   = '0;
            nxt_prev_offset = '0;
         end
         default: begin
            // unused code leaves the entry untouched
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/stride_read_prefetch_predictor.sv -----
// stride_read_prefetch_predictor: per-stream stride prefetch predictor, top level
// holds the entry table, the input and result stages and the threshold register
// depends on srpp_pkg and srpp_update
//
// usage
//   req channel carries one access word: action, stream handle, position, byte count
//   rsp channel returns one result word per access: prefetch request, prediction,
//   hit and conflict flags and the entry's counters after the access
//   csr_wr_en / csr_wr_data set the prefetch run threshold (reset value 4); the user
//   must write it only while no access is in flight, which the block does not enforce
// flow: an access reads its table entry when accepted, the update is computed from
//   the input stage and the result is registered when the input stage moves on
// throughput: one access per cycle; the next access may hit the same entry, the
//   freshly updated entry is forwarded instead of the stale table read
// reset: the table is swept to zero one entry per cycle with req_tready low; config
//   writes are taken during the sweep
// stall: when rsp_tready is low the result register holds, the input stage keeps
//   one more access, then req_tready drops until the result is taken
`default_nettype none

module stride_read_prefetch_predictor #(
   parameter int ENTRIES     = srpp_pkg::ENTRIES_DEF,
   parameter int OFFSET_BITS = srpp_pkg::OFFSET_BITS_DEF,
   parameter int COUNT_BITS  = srpp_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // action[1:0], stream_index[5:2], position[53:6], byte_count[85:54], zero pad
   input  logic [srpp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // prefetch_valid[0], prefetch_offset[48:1], prefetch_size[80:49],
   // prediction_hit[81], write_conflict[82], run_length[114:83],
   // hit_total[146:115], miss_total[178:147], prefetch_total[210:179],
   // prefetched_bytes[258:211], zero pad
   output logic [srpp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [srpp_pkg::THR_BITS-1:0]       csr_wr_data
);

   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SIZE_BITS  = srpp_pkg::SIZE_BITS;
   localparam int CNT_OUT    = srpp_pkg::CNT_OUT_BITS;
   localparam int POS_BITS   = srpp_pkg::POS_BITS;
   // entry layout: run, hit, miss, prefetch count, prefetched sum,
   // predicted offset, predicted size, previous offset (high to low)
   localparam int ENTRY_BITS = 4 * COUNT_BITS + 3 * OFFSET_BITS + SIZE_BITS;
   localparam int PAD_BITS   = srpp_pkg::RSP_TDATA_BITS - srpp_pkg::RSP_FIELD_BITS;

   // request field split
   logic [srpp_pkg::ACTION_BITS-1:0] req_action;
   logic [srpp_pkg::HANDLE_BITS-1:0] req_stream_index;
   logic [POS_BITS-1:0]              req_position;
   logic [SIZE_BITS-1:0]             req_byte_count;
   logic [IDX_BITS-1:0]              req_idx;
   logic                             req_fire;

   assign req_action       = req_tdata[1:0];
   assign req_stream_index = req_tdata[5:2];
   assign req_position     = req_tdata[53:6];
   assign req_byte_count   = req_tdata[85:54];
   assign req_fire         = req_tvalid && req_tready;

   // handle folded onto the table depth
   always_comb begin
      req_idx = '0;
      for (int k = 0; k < (1 << srpp_pkg::HANDLE_BITS); k++) begin
         if (req_stream_index == srpp_pkg::HANDLE_BITS'(k)) begin
            req_idx = IDX_BITS'(k % ENTRIES);
         end
      end
   end

   // threshold register
   logic [srpp_pkg::THR_BITS-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= srpp_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // power-up table sweep
   logic                clr_busy_ff;
   logic [IDX_BITS-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + IDX_BITS'(1);
         if (clr_idx_ff == IDX_BITS'(ENTRIES - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // input stage
   logic                             in_valid_ff;
   logic [srpp_pkg::ACTION_BITS-1:0] in_action_ff;
   logic [IDX_BITS-1:0]              in_idx_ff;
   logic [OFFSET_BITS-1:0]           in_position_ff;
   logic [SIZE_BITS-1:0]             in_byte_count_ff;
   logic                             fwd_ff;
   logic [ENTRY_BITS-1:0]            fwd_entry_ff;
   logic [ENTRY_BITS-1:0]            rd_data_ff;
   logic                             adv;
   logic                             rsp_valid_ff;

   // input stage moves on when the result register is free or being drained
   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!in_valid_ff || adv);

   // table memory
   logic [ENTRY_BITS-1:0] table_mem [ENTRIES];
   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [ENTRY_BITS-1:0] mem_wdata;
   logic [ENTRY_BITS-1:0] new_entry;

   assign mem_we    = clr_busy_ff || adv;
   assign mem_waddr = clr_busy_ff ? clr_idx_ff : in_idx_ff;
   assign mem_wdata = clr_busy_ff ? '0 : new_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_data_ff <= table_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
            // the entry being written at this edge is newer than the table read
            fwd_ff      <= adv && (in_idx_ff == req_idx);
         end else if (adv) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff     <= req_action;
         in_idx_ff        <= req_idx;
         in_position_ff   <= OFFSET_BITS'(req_position);
         in_byte_count_ff <= req_byte_count;
         fwd_entry_ff     <= new_entry;
      end
   end

   // current entry, with forwarding from the previous access
   logic [ENTRY_BITS-1:0]  cur_entry;
   logic [COUNT_BITS-1:0]  cur_run, cur_hit, cur_miss, cur_pf_count;
   logic [OFFSET_BITS-1:0] cur_pf_sum, cur_pred_offset, cur_prev_offset;
   logic [SIZE_BITS-1:0]   cur_pred_size;
   logic [COUNT_BITS-1:0]  nxt_run, nxt_hit, nxt_miss, nxt_pf_count;
   logic [OFFSET_BITS-1:0] nxt_pf_sum, nxt_pred_offset, nxt_prev_offset;
   logic [SIZE_BITS-1:0]   nxt_pred_size;
   srpp_pkg::flag_type     nxt_flags;

   assign cur_entry = fwd_ff ? fwd_entry_ff : rd_data_ff;
   assign {cur_run, cur_hit, cur_miss, cur_pf_count, cur_pf_sum,
           cur_pred_offset, cur_pred_size, cur_prev_offset} = cur_entry;

   srpp_update #(
      .OFFSET_BITS (OFFSET_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_update (
      .action          (in_action_ff),
      .position        (in_position_ff),
      .byte_count      (in_byte_count_ff),
      .threshold       (thr_ff),
      .cur_run         (cur_run),
      .cur_hit         (cur_hit),
      .cur_miss        (cur_miss),
      .cur_pf_count    (cur_pf_count),
      .cur_pf_sum      (cur_pf_sum),
      .cur_pred_offset (cur_pred_offset),
      .cur_pred_size   (cur_pred_size),
      .cur_prev_offset (cur_prev_offset),
      .nxt_run         (nxt_run),
      .nxt_hit         (nxt_hit),
      .nxt_miss        (nxt_miss),
      .nxt_pf_count    (nxt_pf_count),
      .nxt_pf_sum      (nxt_pf_sum),
      .nxt_pred_offset (nxt_pred_offset),
      .nxt_pred_size   (nxt_pred_size),
      .nxt_prev_offset (nxt_prev_offset),
      .flags           (nxt_flags)
   );

   assign new_entry = {nxt_run, nxt_hit, nxt_miss, nxt_pf_count, nxt_pf_sum,
                       nxt_pred_offset, nxt_pred_size, nxt_prev_offset};

   // result register
   srpp_pkg::flag_type   flags_ff;
   logic [POS_BITS-1:0]  pf_offset_ff;
   logic [SIZE_BITS-1:0] pf_size_ff;
   logic [CNT_OUT-1:0]   run_ff, hit_ff, miss_ff, pf_count_ff;
   logic [POS_BITS-1:0]  pf_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flags_ff     <= nxt_flags;
         pf_offset_ff <= POS_BITS'(nxt_pred_offset);
         pf_size_ff   <= nxt_pred_size;
         run_ff       <= CNT_OUT'(nxt_run);
         hit_ff       <= CNT_OUT'(nxt_hit);
         miss_ff      <= CNT_OUT'(nxt_miss);
         pf_count_ff  <= CNT_OUT'(nxt_pf_count);
         pf_bytes_ff  <= POS_BITS'(nxt_pf_sum);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, pf_bytes_ff, pf_count_ff, miss_ff, hit_ff,
                        run_ff, flags_ff.conflict, flags_ff.hit, pf_size_ff,
                        pf_offset_ff, flags_ff.pf_valid};

`ifndef ASSERT_OFF
   // no access is taken while the table is being swept
   assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("access accepted during table sweep");

   // the sweep ends only after the last entry was cleared
   assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_idx_ff) == IDX_BITS'(ENTRIES - 1))
      else $error("table sweep ended early");

   // a held input stage keeps its entry index
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && $stable(in_idx_ff))
      else $error("input stage lost its access while stalled");

   // a result only appears after an access left the input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result without an access");

   // no forwarding is set up for an access accepted while no entry is being updated
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !adv |=> !fwd_ff)
      else $error("forwarding without an entry update");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for the stride read prefetch predictor
// drives access words on req_, checks each rsp_ result word against a model or known row
// depends on srpp_pkg and the stride_read_prefetch_predictor rtl
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACTION_BITS    = srpp_pkg::ACTION_BITS;
   localparam int HANDLE_BITS    = srpp_pkg::HANDLE_BITS;
   localparam int POS_BITS       = srpp_pkg::POS_BITS;
   localparam int SIZE_BITS      = srpp_pkg::SIZE_BITS;
   localparam int CNT_OUT_BITS   = srpp_pkg::CNT_OUT_BITS;
   localparam int THR_BITS       = srpp_pkg::THR_BITS;
   localparam int REQ_FIELD_BITS = srpp_pkg::REQ_FIELD_BITS;
   localparam int REQ_TDATA_BITS = srpp_pkg::REQ_TDATA_BITS;
   localparam int RSP_FIELD_BITS = srpp_pkg::RSP_FIELD_BITS;
   localparam int RSP_TDATA_BITS = srpp_pkg::RSP_TDATA_BITS;
   localparam logic [THR_BITS-1:0] THR_RESET = srpp_pkg::THR_RESET;

   // action 3 has no meaning in the block: state holds, entry is reported as is
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 150;
   localparam int PHASES        = 5;

   // result word, msb first so a cast from rsp_tdata lines up with the port comment
   typedef struct packed {
      logic [POS_BITS-1:0]     pf_bytes;
      logic [CNT_OUT_BITS-1:0] pf_tot;
      logic [CNT_OUT_BITS-1:0] misses;
      logic [CNT_OUT_BITS-1:0] hits;
      logic [CNT_OUT_BITS-1:0] run;
      logic                    conflict;
      logic                    hit;
      logic [SIZE_BITS-1:0]    pf_size;
      logic [POS_BITS-1:0]     pf_off;
      logic                    pf_valid;
   } access_result_type;

   // one row of the opening table; known rows carry a hand-written result
   typedef struct packed {
      logic [ACTION_BITS-1:0] act;
      logic [HANDLE_BITS-1:0] handle;
      logic [POS_BITS-1:0]    pos;
      logic [SIZE_BITS-1:0]   nbytes;
      logic                   known;
      access_result_type      want;
   } access_row_type;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic [REQ_TDATA_BITS-1:0] req_tdata   = '0;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic                      csr_wr_en   = 1'b0;
   logic [THR_BITS-1:0]       csr_wr_data = '0;

   stride_read_prefetch_predictor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // per-stream prediction state, mirrors the block's entry table
   logic [CNT_OUT_BITS-1:0] run_len      [16];
   logic [CNT_OUT_BITS-1:0] hit_tot      [16];
   logic [CNT_OUT_BITS-1:0] miss_tot     [16];
   logic [CNT_OUT_BITS-1:0] pf_tot       [16];
   logic [POS_BITS-1:0]     pf_bytes_sum [16];
   logic [POS_BITS-1:0]     next_off     [16];
   logic [SIZE_BITS-1:0]    next_size    [16];
   logic [POS_BITS-1:0]     last_pos     [16];
   logic [THR_BITS-1:0]     run_threshold = THR_RESET;

   // stimulus side: one strided stream per handle
   logic [POS_BITS-1:0]     trail_pos    [16];
   logic [POS_BITS-1:0]     trail_stride [16];
   logic [SIZE_BITS-1:0]    trail_len    [16];
   bit                      trail_live   [16];
   logic [HANDLE_BITS-1:0]  last_handle = '0;

   access_result_type pending_results [$];
   access_row_type    opening_rows [$];
   access_result_type seen_word;
   access_result_type due_word;
   logic [THR_BITS-1:0] thr_plan [PHASES];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  calm_phase = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [CNT_OUT_BITS-1:0] bump(input logic [CNT_OUT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // expected result word of one accepted access, entry state updated in place
   function automatic access_result_type predict_access(
                                          input logic [ACTION_BITS-1:0] act,
                                          input logic [HANDLE_BITS-1:0] h,
                                          input logic [POS_BITS-1:0]    pos,
                                          input logic [SIZE_BITS-1:0]   nbytes);
      access_result_type r;
      logic [POS_BITS:0] access_end;
      logic [POS_BITS:0] region_end;
      logic [POS_BITS:0] bytes_sum;
      r = '0;
      case (act)
         srpp_pkg::ACT_READ: begin
            if (pos == next_off[h] && nbytes == next_size[h]) begin
               r.hit      = 1'b1;
               run_len[h] = bump(run_len[h]);
               hit_tot[h] = bump(hit_tot[h]);
            end else begin
               run_len[h]  = '0;
               miss_tot[h] = bump(miss_tot[h]);
            end
            // repeat the last stride, wrapping at the offset width
            next_size[h] = nbytes;
            next_off[h]  = pos + (pos - last_pos[h]);
            if (run_len[h] > CNT_OUT_BITS'(run_threshold)) begin
               r.pf_valid      = 1'b1;
               pf_tot[h]       = bump(pf_tot[h]);
               bytes_sum       = {1'b0, pf_bytes_sum[h]} + (POS_BITS+1)'(nbytes);
               pf_bytes_sum[h] = bytes_sum[POS_BITS] ? '1 : bytes_sum[POS_BITS-1:0];
            end
            last_pos[h] = pos;
         end
         srpp_pkg::ACT_WRITE: begin
            // both ends taken one bit wider so neither sum wraps
            access_end = {1'b0, pos} + (POS_BITS+1)'(nbytes);
            region_end = {1'b0, next_off[h]} + (POS_BITS+1)'(next_size[h]);
            if (access_end > {1'b0, next_off[h]} && region_end > {1'b0, pos}) begin
               r.conflict = 1'b1;
               run_len[h] = '0;
            end
         end
         srpp_pkg::ACT_OPEN: begin
            run_len[h]      = '0;
            hit_tot[h]      = '0;
            miss_tot[h]     = '0;
            pf_tot[h]       = '0;
            pf_bytes_sum[h] = '0;
            next_off[h]     = '0;
            next_size[h]    = '0;
            last_pos[h]     = '0;
         end
         default: ;
      endcase
      r.pf_off   = next_off[h];
      r.pf_size  = next_size[h];
      r.run      = run_len[h];
      r.hits     = hit_tot[h];
      r.misses   = miss_tot[h];
      r.pf_tot   = pf_tot[h];
      r.pf_bytes = pf_bytes_sum[h];
      return r;
   endfunction

   // ---------------------------------------------------------------- driving

   // present one access word, hold it until taken, then log what should come back
   task automatic send_access(input logic [ACTION_BITS-1:0] act,
                              input logic [HANDLE_BITS-1:0] h,
                              input logic [POS_BITS-1:0]    pos,
                              input logic [SIZE_BITS-1:0]   nbytes,
                              input logic                   known,
                              input access_result_type      want);
      access_result_type model_word;
      while (!calm_phase && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_BITS-REQ_FIELD_BITS){1'b0}}, nbytes, pos, h, act};
      do @(posedge clock); while (!req_tready);
      // model always runs so entry state stays in step with known rows
      model_word = predict_access(act, h, pos, nbytes);
      pending_results.push_back(known ? want : model_word);
   endtask

   task automatic plan(input logic [ACTION_BITS-1:0] act, input logic [HANDLE_BITS-1:0] h,
                       input logic [POS_BITS-1:0] pos, input logic [SIZE_BITS-1:0] nbytes);
      opening_rows.push_back({act, h, pos, nbytes, 1'b0, access_result_type'('0)});
   endtask

   task automatic plan_known(input logic [ACTION_BITS-1:0] act,
                             input logic [HANDLE_BITS-1:0] h,
                             input logic [POS_BITS-1:0] pos,
                             input logic [SIZE_BITS-1:0] nbytes,
                             input access_result_type want);
      opening_rows.push_back({act, h, pos, nbytes, 1'b1, want});
   endtask

   // hand-written result word, fields in port order
   function automatic access_result_type result_of(input logic pv, input logic [47:0] off,
                                                   input logic [31:0] sz, input logic hit,
                                                   input logic cf, input logic [31:0] run,
                                                   input logic [31:0] hits,
                                                   input logic [31:0] misses,
                                                   input logic [31:0] pfs,
                                                   input logic [47:0] pfb);
      access_result_type r;
      r.pf_valid = pv;
      r.pf_off   = off;
      r.pf_size  = sz;
      r.hit      = hit;
      r.conflict = cf;
      r.run      = run;
      r.hits     = hits;
      r.misses   = misses;
      r.pf_tot   = pfs;
      r.pf_bytes = pfb;
      return r;
   endfunction

   // mostly strided read streams with random content, plus writes mostly aimed
   // at the predicted region, opens, the unused action and random noise
   task automatic random_access();
      int                     pick;
      int                     sel;
      logic [HANDLE_BITS-1:0] h;
      logic [63:0]            r64;
      logic [POS_BITS-1:0]    pos;
      logic [SIZE_BITS-1:0]   nbytes;
      logic [ACTION_BITS-1:0] act;
      pick   = $urandom_range(99);
      h      = ($urandom_range(1) == 1) ? last_handle : HANDLE_BITS'($urandom_range(15));
      r64    = {$urandom, $urandom};
      pos    = r64[POS_BITS-1:0];
      nbytes = $urandom;
      act    = srpp_pkg::ACT_READ;
      if (pick < 68) begin
         if (!trail_live[h] || $urandom_range(24) == 0) begin
            // start a fresh stream on this handle
            sel = $urandom_range(9);
            if ($urandom_range(9) == 0)
               trail_len[h] = '0;
            else if ($urandom_range(9) == 0)
               trail_len[h] = $urandom;
            else
               trail_len[h] = $urandom_range(1, 4096);
            r64 = {$urandom, $urandom};
            case (sel)
               0:             trail_stride[h] = '0;
               1, 2, 3, 4, 5: trail_stride[h] = POS_BITS'($urandom_range(1, 8192));
               6, 7:          trail_stride[h] = -POS_BITS'($urandom_range(1, 8192));
               8:             trail_stride[h] = r64[POS_BITS-1:0];
               default:       trail_stride[h] = POS_BITS'(trail_len[h]);
            endcase
            r64 = {$urandom, $urandom};
            trail_pos[h]  = ($urandom_range(1) == 1) ? r64[POS_BITS-1:0]
                                                     : POS_BITS'($urandom_range(65535));
            trail_live[h] = 1'b1;
         end
         pos          = trail_pos[h];
         nbytes       = trail_len[h];
         trail_pos[h] = trail_pos[h] + trail_stride[h];
      end else if (pick < 78) begin
         act = srpp_pkg::ACT_WRITE;
         case ($urandom_range(2))
            // around the start of the predicted region
            0: begin
               pos    = next_off[h] + POS_BITS'($urandom_range(16)) - POS_BITS'(8);
               nbytes = $urandom_range(16);
            end
            // around its end, pos equal to the end must not overlap
            1: begin
               pos    = next_off[h] + POS_BITS'(next_size[h]) - POS_BITS'($urandom_range(4));
               nbytes = $urandom_range(4);
            end
            default: ;
         endcase
      end else if (pick < 84) begin
         act = srpp_pkg::ACT_OPEN;
      end else if (pick < 89) begin
         act = ACT_UNUSED;
      end
      last_handle = h;
      send_access(act, h, pos, nbytes, 1'b0, '0);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // result side stalls at random except in the calm phase
   always @(posedge clock) begin
      rsp_tready <= calm_phase || ($urandom_range(99) >= 30);
   end

   // every result word taken is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_word = access_result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            due_word = pending_results.pop_front();
            check_field("prefetch_valid",   64'(due_word.pf_valid), 64'(seen_word.pf_valid));
            check_field("prefetch_offset",  64'(due_word.pf_off),   64'(seen_word.pf_off));
            check_field("prefetch_size",    64'(due_word.pf_size),  64'(seen_word.pf_size));
            check_field("prediction_hit",   64'(due_word.hit),      64'(seen_word.hit));
            check_field("write_conflict",   64'(due_word.conflict), 64'(seen_word.conflict));
            check_field("run_length",       64'(due_word.run),      64'(seen_word.run));
            check_field("hit_total",        64'(due_word.hits),     64'(seen_word.hits));
            check_field("miss_total",       64'(due_word.misses),   64'(seen_word.misses));
            check_field("prefetch_total",   64'(due_word.pf_tot),   64'(seen_word.pf_tot));
            check_field("prefetched_bytes", 64'(due_word.pf_bytes), 64'(seen_word.pf_bytes));
         end
      end
   end

   // watchdog, covers the reset sweep and the slowest stall pattern many times over
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < 16; i++) begin
         run_len[i]      = '0;
         hit_tot[i]      = '0;
         miss_tot[i]     = '0;
         pf_tot[i]       = '0;
         pf_bytes_sum[i] = '0;
         next_off[i]     = '0;
         next_size[i]    = '0;
         last_pos[i]     = '0;
         trail_live[i]   = 1'b0;
      end
      // threshold per random phase: both extremes, a mid value, one, and back to reset
      thr_plan[0] = 8'd0;
      thr_plan[1] = 8'd255;
      thr_plan[2] = THR_BITS'($urandom_range(2, 254));
      thr_plan[3] = 8'd1;
      thr_plan[4] = THR_RESET;

      // opening table, run at the reset threshold
      // fresh entry predicts offset 0 size 0, so a zero read hits
      plan_known(srpp_pkg::ACT_READ, 4'd0, '0, '0,
                 result_of(1'b0, '0, '0, 1'b1, 1'b0, 32'd1, 32'd1, '0, '0, '0));
      // largest access, predicted offset 2*max wraps to max-1
      plan_known(srpp_pkg::ACT_READ, 4'd1, '1, '1,
                 result_of(1'b0, 48'hFFFF_FFFF_FFFE, '1, 1'b0, 1'b0, '0, '0, 32'd1, '0, '0));
      plan(srpp_pkg::ACT_WRITE, 4'd1, '0, '0);
      // zero-byte write strictly inside the region still overlaps
      plan_known(srpp_pkg::ACT_WRITE, 4'd1, '1, '0,
                 result_of(1'b0, 48'hFFFF_FFFF_FFFE, '1, 1'b0, 1'b1, '0, '0, 32'd1, '0, '0));
      // zero bytes right at the region start, and a write ending at or just past it
      plan(srpp_pkg::ACT_WRITE, 4'd1, 48'hFFFF_FFFF_FFFE, '0);
      plan(srpp_pkg::ACT_WRITE, 4'd1, 48'hFFFF_FFFF_FFFD, 32'd1);
      plan(srpp_pkg::ACT_WRITE, 4'd1, 48'hFFFF_FFFF_FFFD, 32'd2);
      plan(ACT_UNUSED, 4'd1, 48'h5A5A_A5A5_0F0F, 32'hC3C3_3C3C);
      // open wipes the entry
      plan_known(srpp_pkg::ACT_OPEN, 4'd1, 48'h1234_5678_9ABC, 32'h55AA_AA55,
                 result_of(1'b0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0));
      // untouched top handle reports a clean entry
      plan_known(ACT_UNUSED, 4'd15, '1, '1,
                 result_of(1'b0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0));
      // forward stride long enough to pass the threshold and prefetch
      for (int i = 1; i <= 7; i++)
         plan(srpp_pkg::ACT_READ, 4'd2, POS_BITS'(i * 'h1000), 32'd64);
      plan(srpp_pkg::ACT_WRITE, 4'd2, 48'h800A, 32'd1);
      plan(srpp_pkg::ACT_READ, 4'd2, 48'h8000, 32'd64);
      // backward stride wrapping below zero
      plan(srpp_pkg::ACT_READ, 4'd3, 48'h10, 32'd8);
      plan(srpp_pkg::ACT_READ, 4'd3, 48'h0, 32'd8);
      plan(srpp_pkg::ACT_READ, 4'd3, 48'hFFFF_FFFF_FFF0, 32'd8);
      plan(srpp_pkg::ACT_READ, 4'd3, 48'hFFFF_FFFF_FFE0, 32'd8);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_access(opening_rows[i].act, opening_rows[i].handle, opening_rows[i].pos,
                     opening_rows[i].nbytes, opening_rows[i].known, opening_rows[i].want);
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         // threshold only changes with nothing in flight
         while (pending_results.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= thr_plan[ph];
         @(posedge clock);
         csr_wr_en     <= 1'b0;
         run_threshold  = thr_plan[ph];
         // one phase runs with no idling on either side
         calm_phase = (ph == 2);
         for (int k = 0; k < PHASE_WORDS; k++)
            random_access();
         req_tvalid <= 1'b0;
      end
      calm_phase = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
sv/srpp_pkg.sv
sv/srpp_update.sv
sv/stride_read_prefetch_predictor.sv
verif/tb_top.sv
